/* hw/rtl/vor_pkg.sv */
// ----------------------------------------------------------------------------
// vor_pkg
// Shared types and constants of the vertical OR filter.
// ----------------------------------------------------------------------------
package vor_pkg;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CFG_W  = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // position of one pixel in the frame, as seen by the filter stage
    typedef struct packed {
        logic has_above;    // a row above exists, so a finished pixel leaves
        logic above_first;  // the row above is the first row: passes unchanged
        logic last_row;     // the pixel itself leaves too
        logic row_end;      // last pixel of its row
    } pos_flags_t;

endpackage

/* hw/rtl/vor_ram.sv */
// ----------------------------------------------------------------------------
// vor_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vor_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/vor_pos_cnt.sv */
// ----------------------------------------------------------------------------
// vor_pos_cnt
// Size registers and column/row counters of the incoming raster.
// ----------------------------------------------------------------------------
module vor_pos_cnt #(
    parameter int MAX_WIDTH  = vor_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = vor_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [vor_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [vor_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          advance,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output vor_pkg::pos_flags_t           flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WS_W  = $clog2(MAX_WIDTH + 1);
    localparam int HS_W  = $clog2(MAX_HEIGHT + 1);
    localparam int MS_W  = (WS_W > HS_W) ? WS_W : HS_W;
    localparam int SZ_W  = (MS_W > vor_pkg::CFG_W) ? MS_W : vor_pkg::CFG_W;

    logic [vor_pkg::CFG_W-1:0] width_reg;
    logic [vor_pkg::CFG_W-1:0] height_reg;
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;

    logic [SZ_W-1:0] width_ext;
    logic [SZ_W-1:0] height_ext;
    logic [SZ_W-1:0] width_eff;
    logic [SZ_W-1:0] height_eff;
    logic            row_end;
    logic            last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= vor_pkg::IMAGE_WIDTH_RESET;
            height_reg <= vor_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                vor_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                vor_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize is held at the maximum
    assign width_ext  = SZ_W'(width_reg);
    assign height_ext = SZ_W'(height_reg);

    always_comb begin
        if (width_ext == '0) begin
            width_eff = SZ_W'(1);
        end else if (width_ext > SZ_W'(MAX_WIDTH)) begin
            width_eff = SZ_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext == '0) begin
            height_eff = SZ_W'(1);
        end else if (height_ext > SZ_W'(MAX_HEIGHT)) begin
            height_eff = SZ_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_ext;
        end
    end

    // >= so a counter left beyond a shrunk size wraps at its next step
    assign row_end  = (SZ_W'(col_reg) + SZ_W'(1)) >= width_eff;
    assign last_row = (SZ_W'(row_reg) + SZ_W'(1)) >= height_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col               = col_reg;
    assign flags.has_above   = (row_reg != '0);
    assign flags.above_first = (row_reg == ROW_W'(1));
    assign flags.last_row    = last_row;
    assign flags.row_end     = row_end;

endmodule

/* hw/rtl/vor_out_stage.sv */
// ----------------------------------------------------------------------------
// vor_out_stage
// Filter stage: combines the line store data with the held pixel and feeds
// the result register, zero, one or two results per pixel.
// ----------------------------------------------------------------------------
module vor_out_stage #(
    parameter int MAX_WIDTH = vor_pkg::MAX_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // new pixel, taken when in_take is high
    input  logic                           in_take,
    output logic                           in_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0]   in_col,
    input  vor_pkg::pos_flags_t            in_flags,
    input  logic [vor_pkg::PIX_W-1:0]      in_pix,
    // line store
    input  logic [2*vor_pkg::PIX_W-1:0]    ram_rd_data,
    output logic                           ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0]   ram_waddr,
    output logic [2*vor_pkg::PIX_W-1:0]    ram_wdata,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vor_pkg::CH_W-1:0]       m_out_blue,
    output logic [vor_pkg::CH_W-1:0]       m_out_green,
    output logic [vor_pkg::CH_W-1:0]       m_out_red,
    output logic                           m_run_last,
    output logic                           m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PW    = vor_pkg::PIX_W;
    localparam int CW    = vor_pkg::CH_W;

    logic                s1_valid_reg;
    logic [COL_W-1:0]    s1_col_reg;
    vor_pkg::pos_flags_t s1_flags_reg;
    logic [PW-1:0]       s1_pix_reg;
    logic                s1_phase_reg;
    logic                byp_hit_reg;
    logic [2*PW-1:0]     byp_data_reg;

    logic                m_valid_reg;
    logic [PW-1:0]       m_pix_reg;
    logic                m_run_last_reg;
    logic                m_frame_end_reg;

    logic [2*PW-1:0]     rows;
    logic [PW-1:0]       older;
    logic [PW-1:0]       newer;
    logic [PW-1:0]       above;
    logic                need_above;
    logic                need_self;
    logic                need_any;
    logic                out_free;
    logic                emit_fire;
    logic                emit_above;
    logic                s1_done;

    // a write to the same column at the read edge is not seen by the ram
    assign rows  = byp_hit_reg ? byp_data_reg : ram_rd_data;
    assign older = rows[2*PW-1:PW];
    assign newer = rows[PW-1:0];
    assign above = s1_flags_reg.above_first ? newer : (older | newer | s1_pix_reg);

    assign need_above = s1_flags_reg.has_above;
    assign need_self  = s1_flags_reg.last_row;
    assign need_any   = need_above || need_self;
    assign out_free   = !m_valid_reg || m_ready;
    assign emit_above = need_above && !s1_phase_reg;
    assign emit_fire  = s1_valid_reg && need_any && out_free;
    assign s1_done    = s1_valid_reg && (!need_any ||
                        (out_free && !(emit_above && need_self)));

    assign in_ready = !s1_valid_reg || s1_done;

    assign ram_we    = s1_done;
    assign ram_waddr = s1_col_reg;
    assign ram_wdata = {newer, s1_pix_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else begin
            if (in_take) begin
                s1_valid_reg <= 1'b1;
                byp_hit_reg  <= s1_done && (s1_col_reg == in_col);
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done) begin
                s1_phase_reg <= 1'b0;
            end else if (emit_fire) begin
                s1_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_col_reg   <= in_col;
            s1_flags_reg <= in_flags;
            s1_pix_reg   <= in_pix;
            byp_data_reg <= ram_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            if (emit_above) begin
                m_pix_reg       <= above;
                m_run_last_reg  <= !need_self;
                m_frame_end_reg <= 1'b0;
            end else begin
                m_pix_reg       <= s1_pix_reg;
                m_run_last_reg  <= 1'b1;
                m_frame_end_reg <= s1_flags_reg.row_end;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_blue  = m_pix_reg[CW-1:0];
    assign m_out_green = m_pix_reg[2*CW-1:CW];
    assign m_out_red   = m_pix_reg[3*CW-1:2*CW];
    assign m_run_last  = m_run_last_reg;
    assign m_frame_end = m_frame_end_reg;

    // a pixel with results pending never retires while the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && need_any && !out_free |-> !s1_done)
        else $error("filter stage retired with blocked output");

    // the second-result phase only exists for last-row pixels with a row above
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_phase_reg |-> s1_valid_reg && need_above && need_self)
        else $error("second-result phase on wrong pixel");

    // entering the second phase means the first result just went out, not last
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s1_phase_reg) |-> m_valid_reg && !m_run_last_reg)
        else $error("first of two results marked last");

    // a bypass hit only follows a retire and take in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_take && !s1_done |=> !byp_hit_reg)
        else $error("bypass hit without concurrent store write");

endmodule

/* hw/rtl/vertical_or_filter_rgb.sv */
// order: a pixel of row r reaches the result register from the filter stage
//   register once the pixel below (row r+1) is in it; last-row pixels follow
// throughput: one item per cycle while the output is free; a last-row item
//   with a row above gives two results through the single result register
// reset: counters to zero, size to 640 x 480; line stores are not cleared
// ----------------------------------------------------------------------------
// vertical_or_filter_rgb
// Vertical three-tap bitwise OR filter over a BGR raster with line stores.
// ----------------------------------------------------------------------------
module vertical_or_filter_rgb #(
    parameter int MAX_WIDTH  = vor_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = vor_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [vor_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [vor_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [vor_pkg::CH_W-1:0]      s_in_blue,
    input  logic [vor_pkg::CH_W-1:0]      s_in_green,
    input  logic [vor_pkg::CH_W-1:0]      s_in_red,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vor_pkg::CH_W-1:0]      m_out_blue,
    output logic [vor_pkg::CH_W-1:0]      m_out_green,
    output logic [vor_pkg::CH_W-1:0]      m_out_red,
    output logic                          m_run_last,
    output logic                          m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PW    = vor_pkg::PIX_W;

    logic                s_take;
    logic [COL_W-1:0]    col;
    vor_pkg::pos_flags_t flags;
    logic [PW-1:0]       in_pix;
    logic [2*PW-1:0]     ram_rd_data;
    logic                ram_we;
    logic [COL_W-1:0]    ram_waddr;
    logic [2*PW-1:0]     ram_wdata;

    assign s_take = s_valid && s_ready;
    assign in_pix = {s_in_red, s_in_green, s_in_blue};

    vor_pos_cnt #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos_cnt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .advance   (s_take),
        .col       (col),
        .flags     (flags)
    );

    // both line stores in one word: older row high, newer row low
    vor_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (s_take),
        .rd_addr (col),
        .rd_data (ram_rd_data)
    );

    vor_out_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_take     (s_take),
        .in_ready    (s_ready),
        .in_col      (col),
        .in_flags    (flags),
        .in_pix      (in_pix),
        .ram_rd_data (ram_rd_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_blue  (m_out_blue),
        .m_out_green (m_out_green),
        .m_out_red   (m_out_red),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

endmodule
